// ===== hdl/assert_macros.svh =====
// Assertion macros used by the node policy selector core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/nnps_pkg.sv =====
// Package with constants, codes and types of the node policy selector.
`default_nettype none

package nnps_pkg;

   // Node numbering and mask geometry.
   localparam int NODE_COUNT  = 64;
   localparam int MASK_W      = 64;
   localparam int NODE_W      = 6;
   localparam int BYTE_COUNT  = MASK_W / 8;
   localparam int BYTE_IDX_W  = $clog2(BYTE_COUNT);
   localparam int COUNT_W     = 7;
   localparam int OFFSET_W    = 32;
   localparam int DIV_STEP_W  = $clog2(OFFSET_W);

   typedef logic [NODE_W-1:0] node_type;

   // Policy modes.
   localparam logic [1:0] MODE_DEFAULT    = 2'd0;
   localparam logic [1:0] MODE_PREFERRED  = 2'd1;
   localparam logic [1:0] MODE_BIND       = 2'd2;
   localparam logic [1:0] MODE_INTERLEAVE = 2'd3;

   // Request opcodes.
   localparam logic [1:0] OP_PICK    = 2'd0;
   localparam logic [1:0] OP_OFFSET  = 2'd1;
   localparam logic [1:0] OP_QUERY   = 2'd2;
   localparam logic [1:0] OP_RESTART = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] REG_POLICY_MODE    = 2'd0;
   localparam logic [1:0] REG_NODE_MASK      = 2'd1;
   localparam logic [1:0] REG_PREFERRED_NODE = 2'd2;

   // Outcome of one byte step of the mask scanner.
   typedef struct packed {
      logic       hit;
      logic [2:0] pos;
      logic [3:0] pop;
   } scan_step_type;

   // Status of the iterative modulo unit.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ===== hdl/numa_node_policy_selector_core.sv =====
// Top level of the node policy selector: registers, sequencer and ports.
//
//   Channel   Direction  Handshake              Contents
//   req_      in         req_tvalid/req_tready  tuser opcode, tdata node and offset fields
//   rsp_      out        rsp_tvalid/rsp_tready  tdata chosen node and two flags
//   csr_      in         csr_valid/csr_ready    register index and write data
//
// Query, default, preferred and empty-mask requests go from acceptance straight
// to the write-back state, which loads the response register. Bind picks and
// cursor restarts add one pass of the byte-wide mask scanner, process interleave
// up to two. Offset interleave takes a counting scan, a run of the bit-per-cycle
// modulo unit and a rank scan. Reset is synchronous; it restores the config
// registers and clears the cursor. A stalled response holds its word, and a new
// request is taken meanwhile; its result waits in write-back till the slot frees.
`default_nettype none
`include "assert_macros.svh"

module numa_node_policy_selector_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: local_node[5:0], page_offset[37:6], query_node[43:38], zero [47:44]
   input  wire logic [47:0] req_tdata,
   // tuser: opcode[1:0]
   input  wire logic [1:0]  req_tuser,
   // Response stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: chosen_node[5:0], node_allowed[6], policy_error[7]
   output logic [7:0]       rsp_tdata,
   // Configuration write channel.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import nnps_pkg::*;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_WRITE = 2'd3;

   // What a finished scan is used for.
   localparam logic [2:0] GOAL_RESTART = 3'd0;
   localparam logic [2:0] GOAL_BIND    = 3'd1;
   localparam logic [2:0] GOAL_COUNT   = 3'd2;
   localparam logic [2:0] GOAL_NTH     = 3'd3;
   localparam logic [2:0] GOAL_ABOVE   = 3'd4;
   localparam logic [2:0] GOAL_WRAP    = 3'd5;

   localparam logic [COUNT_W-1:0] RANK_NONE = '1;

   // Configuration and cursor.
   logic [1:0]          mode_ff;
   logic [MASK_W-1:0]   mask_ff;
   logic [6:0]          pref_ff;
   node_type            cursor_ff, cursor_in;

   // Sequencer and scanner.
   logic [1:0]            state_ff, state_in;
   logic [2:0]            goal_ff, goal_in;
   logic [MASK_W-1:0]     scan_mask_ff, scan_mask_in;
   logic [BYTE_IDX_W-1:0] scan_byte_ff, scan_byte_in;
   logic [COUNT_W-1:0]    scan_count_ff, scan_count_in;
   logic [COUNT_W-1:0]    scan_rank_ff, scan_rank_in;
   logic [OFFSET_W-1:0]   offset_ff, offset_in;

   // Pending result and response slot.
   node_type            res_chosen_ff, res_chosen_in;
   logic                res_allowed_ff, res_allowed_in;
   logic                res_error_ff, res_error_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_data_ff, rsp_data_in;

   // Request fields.
   logic [1:0]          req_opcode;
   node_type            req_local;
   logic [OFFSET_W-1:0] req_offset;
   node_type            req_query;

   logic [MASK_W-1:0]   live_mask;
   logic [MASK_W-1:0]   above_mask;
   logic                mask_empty;
   logic                masked_mode;
   logic                req_error;
   logic                req_accept;

   scan_step_type       step;
   logic [COUNT_W-1:0]  count_sum;
   node_type            scan_pos;
   logic                scan_end;
   logic                div_start;
   div_status_type      div_status;
   node_type            div_rem;

   assign req_opcode = req_tuser;
   assign req_local  = req_tdata[5:0];
   assign req_offset = req_tdata[37:6];
   assign req_query  = req_tdata[43:38];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Mask bits of nodes that exist, and those strictly above the cursor.
   always_comb begin
      for (int i = 0; i < MASK_W; i++) begin
         live_mask[i]  = mask_ff[i] && (i < NODE_COUNT);
         above_mask[i] = live_mask[i] && (NODE_W'(i) > cursor_ff);
      end
   end

   assign mask_empty  = (live_mask == '0);
   assign masked_mode = (mode_ff == MODE_BIND) || (mode_ff == MODE_INTERLEAVE);
   assign req_error   = masked_mode && mask_empty;

   // Shared byte step over the mask being scanned.
   nnps_scan_step u_scan_step (
      .byte_bits   (scan_mask_ff[scan_byte_ff*8 +: 8]),
      .base_count  (scan_count_ff),
      .target_rank (scan_rank_ff),
      .step        (step)
   );

   assign count_sum = scan_count_ff + COUNT_W'(step.pop);
   assign scan_pos  = {scan_byte_ff, step.pos};
   assign scan_end  = step.hit || (scan_byte_ff == BYTE_IDX_W'(BYTE_COUNT - 1));

   // Modulo of the page offset by the set-bit count.
   nnps_mod_unit u_mod_unit (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (offset_ff),
      .divisor   (count_sum),
      .status    (div_status),
      .remainder (div_rem)
   );

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      goal_in        = goal_ff;
      scan_mask_in   = scan_mask_ff;
      scan_byte_in   = scan_byte_ff;
      scan_count_in  = scan_count_ff;
      scan_rank_in   = scan_rank_ff;
      offset_in      = offset_ff;
      cursor_in      = cursor_ff;
      res_chosen_in  = res_chosen_ff;
      res_allowed_in = res_allowed_ff;
      res_error_in   = res_error_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      div_start      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               res_chosen_in  = '0;
               res_allowed_in = 1'b0;
               res_error_in   = req_error;
               offset_in      = req_offset;
               scan_mask_in   = live_mask;
               scan_byte_in   = '0;
               scan_count_in  = '0;
               scan_rank_in   = '0;
               state_in       = ST_WRITE;
               if (req_opcode == OP_RESTART) begin
                  if (mask_empty) begin
                     cursor_in = '0;
                  end else begin
                     goal_in  = GOAL_RESTART;
                     state_in = ST_SCAN;
                  end
               end else if (req_error) begin
                  state_in = ST_WRITE;
               end else if (req_opcode == OP_QUERY) begin
                  if (mode_ff == MODE_BIND) begin
                     res_allowed_in = (int'(req_query) < NODE_COUNT) && live_mask[req_query];
                  end else begin
                     res_allowed_in = 1'b1;
                  end
               end else begin
                  case (mode_ff)
                     MODE_DEFAULT: begin
                        res_chosen_in = req_local;
                     end
                     MODE_PREFERRED: begin
                        if (!pref_ff[6] && int'(pref_ff) < NODE_COUNT) begin
                           res_chosen_in = pref_ff[NODE_W-1:0];
                        end else begin
                           res_chosen_in = req_local;
                        end
                     end
                     MODE_BIND: begin
                        goal_in  = GOAL_BIND;
                        state_in = ST_SCAN;
                     end
                     default: begin
                        state_in = ST_SCAN;
                        if (req_opcode == OP_OFFSET) begin
                           goal_in      = GOAL_COUNT;
                           scan_rank_in = RANK_NONE;
                        end else begin
                           // Answer the cursor, then look for the next node above it.
                           res_chosen_in = cursor_ff;
                           goal_in       = GOAL_ABOVE;
                           scan_mask_in  = above_mask;
                        end
                     end
                  endcase
               end
            end
         end

         ST_SCAN: begin
            scan_count_in = count_sum;
            scan_byte_in  = scan_byte_ff + 1'b1;
            if (scan_end) begin
               state_in = ST_WRITE;
               case (goal_ff)
                  GOAL_RESTART: begin
                     cursor_in = scan_pos;
                  end
                  GOAL_BIND, GOAL_NTH: begin
                     res_chosen_in = scan_pos;
                  end
                  GOAL_COUNT: begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
                  GOAL_ABOVE: begin
                     if (step.hit) begin
                        cursor_in = scan_pos;
                     end else begin
                        // Nothing above the cursor: wrap to the lowest node.
                        goal_in       = GOAL_WRAP;
                        scan_mask_in  = live_mask;
                        scan_byte_in  = '0;
                        scan_count_in = '0;
                        scan_rank_in  = '0;
                        state_in      = ST_SCAN;
                     end
                  end
                  default: begin
                     cursor_in = scan_pos;
                  end
               endcase
            end
         end

         ST_DIV: begin
            if (div_status.done) begin
               goal_in       = GOAL_NTH;
               scan_mask_in  = live_mask;
               scan_byte_in  = '0;
               scan_count_in = '0;
               scan_rank_in  = {1'b0, div_rem};
               state_in      = ST_SCAN;
            end
         end

         default: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_error_ff, res_allowed_ff, res_chosen_ff};
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   // Configuration writes, sequencer and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_DEFAULT;
         mask_ff      <= '0;
         pref_ff      <= 7'h7F;
         cursor_ff    <= '0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_POLICY_MODE:    mode_ff <= csr_data[1:0];
               REG_NODE_MASK:      mask_ff <= csr_data;
               REG_PREFERRED_NODE: pref_ff <= csr_data[6:0];
               default:            ;
            endcase
         end
         cursor_ff    <= cursor_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      goal_ff        <= goal_in;
      scan_mask_ff   <= scan_mask_in;
      scan_byte_ff   <= scan_byte_in;
      scan_count_ff  <= scan_count_in;
      scan_rank_ff   <= scan_rank_in;
      offset_ff      <= offset_in;
      res_chosen_ff  <= res_chosen_in;
      res_allowed_ff <= res_allowed_in;
      res_error_ff   <= res_error_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks on the sequencer and the result word.
   `ASSERT_RST(a_busy_after_accept, clock, reset, req_accept |=> !req_tready,
               "accepted request did not make the block busy")
   `ASSERT_RST(a_div_active, clock, reset,
               (state_ff == ST_DIV) |-> (div_status.busy || div_status.done),
               "waiting on an idle modulo unit")
   `ASSERT_ALWAYS(a_error_zero, clock,
                  (rsp_tvalid && rsp_tdata[7]) |-> (rsp_tdata[6:0] == 7'd0),
                  "error word carries a node or an allowed flag")

endmodule

`default_nettype wire

// ===== hdl/nnps_scan_step.sv =====
// One byte step of the mask scanner: set-bit count and rank search.
`default_nettype none

module nnps_scan_step (
   input  wire logic [7:0]                     byte_bits,
   input  wire logic [nnps_pkg::COUNT_W-1:0]   base_count,
   input  wire logic [nnps_pkg::COUNT_W-1:0]   target_rank,
   output nnps_pkg::scan_step_type             step
);
   import nnps_pkg::*;

   logic [COUNT_W-1:0] rank;

   // Walk the eight bits, counting set bits and marking the one whose
   // rank over the whole mask equals the target.
   always_comb begin
      rank      = base_count;
      step.hit  = 1'b0;
      step.pos  = 3'd0;
      step.pop  = 4'd0;
      for (int i = 0; i < 8; i++) begin
         if (byte_bits[i]) begin
            if (!step.hit && rank == target_rank) begin
               step.hit = 1'b1;
               step.pos = 3'(i);
            end
            rank     = rank + 1'b1;
            step.pop = step.pop + 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/nnps_mod_unit.sv =====
// Iterative restoring modulo unit: one dividend bit per cycle.
`default_nettype none

module nnps_mod_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [nnps_pkg::OFFSET_W-1:0]  dividend,
   input  wire logic [nnps_pkg::COUNT_W-1:0]   divisor,
   output nnps_pkg::div_status_type            status,
   output nnps_pkg::node_type                  remainder
);
   import nnps_pkg::*;

   logic [OFFSET_W-1:0]   quot_ff,  quot_in;
   node_type              rem_ff,   rem_in;
   logic [COUNT_W-1:0]    div_ff,   div_in;
   logic [DIV_STEP_W-1:0] step_ff,  step_in;
   logic                  busy_ff,  busy_in;
   logic                  done_ff,  done_in;
   logic [COUNT_W-1:0]    shifted;

   // The partial remainder stays below the divisor, which is at most the
   // node count, so it fits a node number.
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quot_ff[OFFSET_W-1]};
      if (start) begin
         quot_in = dividend;
         div_in  = divisor;
         rem_in  = '0;
         step_in = DIV_STEP_W'(OFFSET_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[OFFSET_W-2:0], 1'b0};
         if (shifted >= div_ff) begin
            rem_in = NODE_W'(shifted - div_ff);
         end else begin
            rem_in = shifted[NODE_W-1:0];
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   // Control flops reset; the datapath needs none.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      step_ff <= step_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

`default_nettype wire
